FILE: rtl/jbru_pkg.sv
`timescale 1ns / 1ps

package jbru_pkg;

   // Bit store capacity and the largest field one read may take.
   localparam int BufferBits = 64;
   localparam int MaxRequest = 32;
   localparam int HeldWidth  = $clog2(BufferBits + 1);

   localparam logic [7:0] MarkerByte  = 8'hFF;
   localparam logic [7:0] StuffByte   = 8'h00;
   localparam logic [4:0] RestartHigh = 5'b11010;

   typedef enum logic [1:0] {
      MODE_PUSH  = 2'd0,
      MODE_READ  = 2'd1,
      MODE_CLEAR = 2'd2
   } mode_type;

   typedef enum logic [1:0] {
      STATUS_OK            = 2'd0,
      STATUS_OUT_OF_STREAM = 2'd1,
      STATUS_LOST_SYNC     = 2'd2,
      STATUS_RESTART       = 2'd3
   } status_type;

   typedef struct packed {
      mode_type   mode;
      logic [7:0] byte_in;
      logic [5:0] bits_wanted;
   } item_type;

   typedef struct packed {
      logic [31:0] bits_out;
      logic        bits_valid;
      logic        short_of_bits;
      logic        byte_accepted;
      status_type  status;
      logic [6:0]  bits_held;
      logic [15:0] stuffers_seen;
   } result_type;

endpackage

FILE: rtl/jbru_core.sv
`timescale 1ns / 1ps

module jbru_core (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step,
   input  jbru_pkg::item_type   item,
   output jbru_pkg::result_type result
);
   import jbru_pkg::*;

   logic [BufferBits-1:0] store_ff, store_in;
   logic [HeldWidth-1:0]  held_ff, held_in;
   logic                  pending_ff, pending_in;
   status_type            status_ff, status_in;
   logic [15:0]           stuffers_ff, stuffers_in;

   logic [5:0]            want;
   logic [HeldWidth-1:0]  shift_amount;
   logic [BufferBits-1:0] extracted;
   logic [BufferBits-1:0] append_value;
   logic [7:0]            append_byte;
   logic                  do_append;
   logic                  room;

   // Bits beyond held_ff are kept at zero, so an append is a plain OR.
   always_comb begin
      want         = (item.bits_wanted > 6'(MaxRequest)) ? 6'(MaxRequest) : item.bits_wanted;
      shift_amount = HeldWidth'(BufferBits) - HeldWidth'(want);
      extracted    = store_ff >> shift_amount;
      room         = held_ff <= HeldWidth'(BufferBits - 8);
      append_byte  = item.byte_in;
      do_append    = 1'b0;

      store_in    = store_ff;
      held_in     = held_ff;
      pending_in  = pending_ff;
      status_in   = status_ff;
      stuffers_in = stuffers_ff;

      result.bits_out      = '0;
      result.bits_valid    = 1'b0;
      result.short_of_bits = 1'b0;
      result.byte_accepted = 1'b0;

      unique case (item.mode)
         MODE_PUSH: begin
            if (status_ff != STATUS_OK) begin
               result.byte_accepted = 1'b0;
            end else if (pending_ff) begin
               pending_in = 1'b0;
               if (item.byte_in == StuffByte) begin
                  append_byte          = MarkerByte;
                  do_append            = 1'b1;
                  result.byte_accepted = 1'b1;
                  if (stuffers_ff != '1) begin
                     stuffers_in = stuffers_ff + 16'd1;
                  end
               end else if (item.byte_in == MarkerByte) begin
                  status_in = STATUS_OUT_OF_STREAM;
               end else if (item.byte_in[7:3] == RestartHigh) begin
                  status_in = STATUS_RESTART;
               end else begin
                  status_in = STATUS_LOST_SYNC;
               end
            end else if (room) begin
               result.byte_accepted = 1'b1;
               if (item.byte_in == MarkerByte) begin
                  pending_in = 1'b1;
               end else begin
                  do_append = 1'b1;
               end
            end
         end
         MODE_READ: begin
            if (HeldWidth'(want) > held_ff) begin
               result.short_of_bits = 1'b1;
            end else begin
               result.bits_out   = extracted[31:0];
               result.bits_valid = 1'b1;
               store_in          = store_ff << want;
               held_in           = held_ff - HeldWidth'(want);
            end
         end
         MODE_CLEAR: begin
            held_in  = '0;
            store_in = '0;
         end
         default: begin
         end
      endcase

      append_value = {append_byte, {(BufferBits - 8){1'b0}}} >> held_ff;
      if (do_append) begin
         store_in = store_ff | append_value;
         held_in  = held_ff + HeldWidth'(8);
      end

      result.status        = status_in;
      result.bits_held     = 7'(held_in);
      result.stuffers_seen = stuffers_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         store_ff    <= '0;
         held_ff     <= '0;
         pending_ff  <= 1'b0;
         status_ff   <= STATUS_OK;
         stuffers_ff <= '0;
      end else if (step) begin
         store_ff    <= store_in;
         held_ff     <= held_in;
         pending_ff  <= pending_in;
         status_ff   <= status_in;
         stuffers_ff <= stuffers_in;
      end
   end

endmodule

FILE: rtl/jpeg_bit_reader_unstuff_top.sv
`timescale 1ns / 1ps

// JPEG entropy-segment bit reader with byte unstuffing. Every request is
// one of: push a stream byte, read 0 to 32 bits (first stream bit most
// significant, right aligned), clear the buffered bits, or an unused mode
// that changes nothing. One request is taken per clock while req_stall is
// low; it waits in the request register, the 64-bit bit store is updated,
// and the response is held in the response register. Errors (out of
// stream, lost sync, unexpected restart marker) are sticky until reset; reads
// are still served from the bits already held.

module jpeg_bit_reader_unstuff_top (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [1:0]             req_mode,
   input  logic [7:0]             req_byte_in,
   input  logic [5:0]             req_bits_wanted,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [31:0]            rsp_bits_out,
   output logic                   rsp_bits_valid,
   output logic                   rsp_short_of_bits,
   output logic                   rsp_byte_accepted,
   output logic [1:0]             rsp_status,
   output logic [6:0]             rsp_bits_held,
   output logic [15:0]            rsp_stuffers_seen
);
   import jbru_pkg::*;

   logic       req_vld_ff, req_vld_in;
   item_type   item_ff;
   logic       rsp_vld_ff, rsp_vld_in;
   result_type rsp_ff;
   result_type result;
   logic       out_free;
   logic       advance;
   logic       accept;

   assign out_free  = !rsp_vld_ff || !rsp_stall;
   assign advance   = req_vld_ff && out_free;
   assign req_stall = req_vld_ff && !out_free;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      req_vld_in = req_vld_ff;
      if (accept) begin
         req_vld_in = 1'b1;
      end else if (advance) begin
         req_vld_in = 1'b0;
      end
      rsp_vld_in = rsp_vld_ff && rsp_stall;
      if (advance) begin
         rsp_vld_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_vld_ff <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         req_vld_ff <= req_vld_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff.mode        <= mode_type'(req_mode);
         item_ff.byte_in     <= req_byte_in;
         item_ff.bits_wanted <= req_bits_wanted;
      end
      if (advance) begin
         rsp_ff <= result;
      end
   end

   jbru_core u_core (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .item   (item_ff),
      .result (result)
   );

   assign rsp_valid         = rsp_vld_ff;
   assign rsp_bits_out      = rsp_ff.bits_out;
   assign rsp_bits_valid    = rsp_ff.bits_valid;
   assign rsp_short_of_bits = rsp_ff.short_of_bits;
   assign rsp_byte_accepted = rsp_ff.byte_accepted;
   assign rsp_status        = rsp_ff.status;
   assign rsp_bits_held     = rsp_ff.bits_held;
   assign rsp_stuffers_seen = rsp_ff.stuffers_seen;

endmodule

FILE: rtl/jbru_checker.sv
`timescale 1ns / 1ps

module jbru_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [31:0] rsp_bits_out,
   input logic        rsp_bits_valid,
   input logic        rsp_short_of_bits,
   input logic [1:0]  rsp_status,
   input logic [6:0]  rsp_bits_held
);
   import jbru_pkg::*;

   logic [1:0] last_status_ff;

   // Status seen on the last response taken; errors never clear.
   always_ff @(posedge clock) begin
      if (reset) begin
         last_status_ff <= STATUS_OK;
      end else if (rsp_valid && !rsp_stall) begin
         last_status_ff <= rsp_status;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && last_status_ff != STATUS_OK |-> rsp_status == last_status_ff)
      else $error("sticky error status changed");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_bits_valid && rsp_short_of_bits))
      else $error("read both satisfied and short");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_bits_valid |-> rsp_bits_out == 32'd0)
      else $error("bits returned without a satisfied read");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_bits_held <= 7'(BufferBits))
      else $error("held bit count beyond store capacity");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_bits_out)
         && $stable(rsp_bits_held))
      else $error("stalled response changed");

endmodule

bind jpeg_bit_reader_unstuff_top jbru_checker u_jbru_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_bits_out      (rsp_bits_out),
   .rsp_bits_valid    (rsp_bits_valid),
   .rsp_short_of_bits (rsp_short_of_bits),
   .rsp_status        (rsp_status),
   .rsp_bits_held     (rsp_bits_held)
);

FILE: tb/sv/jbru_reader_checker.sv
`timescale 1ns / 1ps

module jbru_reader_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [1:0]  req_mode,
   input  logic [7:0]  req_byte_in,
   input  logic [5:0]  req_bits_wanted,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [31:0] rsp_bits_out,
   input  logic        rsp_bits_valid,
   input  logic        rsp_short_of_bits,
   input  logic        rsp_byte_accepted,
   input  logic [1:0]  rsp_status,
   input  logic [6:0]  rsp_bits_held,
   input  logic [15:0] rsp_stuffers_seen,
   output int          fail_count,
   output int          outstanding
);

   import jbru_pkg::*;

   // Bit 63 of store_bits holds the oldest buffered stream bit.
   logic [63:0] store_bits;
   int unsigned held_bits;
   logic        marker_wait;
   status_type  err_state;
   logic [15:0] stuff_cnt;

   result_type awaited_outcomes[$];

   function automatic void append_octet(input logic [7:0] octet);
      store_bits[63 - held_bits -: 8] = octet;
      held_bits += 8;
   endfunction

   function automatic logic take_byte(input logic [7:0] octet);
      if (err_state != STATUS_OK) return 1'b0;
      if (marker_wait) begin
         marker_wait = 1'b0;
         if (octet == StuffByte) begin
            append_octet(MarkerByte);
            if (stuff_cnt != 16'hFFFF) stuff_cnt++;
            return 1'b1;
         end
         if (octet == MarkerByte) begin
            err_state = STATUS_OUT_OF_STREAM;
         end else if (octet[7:3] == RestartHigh) begin
            err_state = STATUS_RESTART;
         end else begin
            err_state = STATUS_LOST_SYNC;
         end
         return 1'b0;
      end
      if (held_bits + 8 > BufferBits) return 1'b0;
      if (octet == MarkerByte) begin
         marker_wait = 1'b1;
         return 1'b1;
      end
      append_octet(octet);
      return 1'b1;
   endfunction

   function automatic result_type reader_step_outcome(input logic [1:0] mode,
                                                      input logic [7:0] octet,
                                                      input logic [5:0] wanted);
      result_type  outcome;
      int unsigned take;
      outcome = '0;
      case (mode)
         MODE_PUSH: begin
            outcome.byte_accepted = take_byte(octet);
         end
         MODE_READ: begin
            take = (wanted > MaxRequest) ? MaxRequest : wanted;
            if (take > held_bits) begin
               outcome.short_of_bits = 1'b1;
            end else begin
               if (take != 0) begin
                  outcome.bits_out = store_bits[63 -: 32] >> (32 - take);
                  store_bits = store_bits << take;
               end
               held_bits -= take;
               outcome.bits_valid = 1'b1;
            end
         end
         MODE_CLEAR: begin
            // Stale bits past the fill level are never read, so zeroing is safe.
            held_bits = 0;
            store_bits = '0;
         end
         default: begin
         end
      endcase
      outcome.status = err_state;
      outcome.bits_held = held_bits[6:0];
      outcome.stuffers_seen = stuff_cnt;
      return outcome;
   endfunction

   task automatic check_field(input string label, input logic [31:0] expected_value,
                              input logic [31:0] actual_value);
      if (expected_value !== actual_value) begin
         $error("%s: expected 0x%0h, got 0x%0h", label, expected_value, actual_value);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin : watch
      result_type oldest;
      if (reset) begin
         awaited_outcomes.delete();
         store_bits = '0;
         held_bits = 0;
         marker_wait = 1'b0;
         err_state = STATUS_OK;
         stuff_cnt = '0;
         fail_count = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (awaited_outcomes.size() == 0) begin
               $error("response arrived with no request outstanding");
               fail_count++;
            end else begin
               oldest = awaited_outcomes.pop_front();
               check_field("bits_out", oldest.bits_out, rsp_bits_out);
               check_field("bits_valid", oldest.bits_valid, rsp_bits_valid);
               check_field("short_of_bits", oldest.short_of_bits, rsp_short_of_bits);
               check_field("byte_accepted", oldest.byte_accepted, rsp_byte_accepted);
               check_field("status", oldest.status, rsp_status);
               check_field("bits_held", oldest.bits_held, rsp_bits_held);
               check_field("stuffers_seen", oldest.stuffers_seen, rsp_stuffers_seen);
            end
         end
         if (req_valid && !req_stall) begin
            awaited_outcomes.push_back(reader_step_outcome(req_mode, req_byte_in,
                                                           req_bits_wanted));
         end
      end
      outstanding = awaited_outcomes.size();
   end

endmodule

FILE: tb/sv/tb_jpeg_bit_reader_unstuff_top.sv
`timescale 1ns / 1ps

module tb_jpeg_bit_reader_unstuff_top;

   import jbru_pkg::*;

   localparam logic [1:0] ModeUnused = 2'd3;
   localparam int HoldCycles = 300;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_mode = MODE_PUSH;
   logic [7:0]  req_byte_in = 8'h00;
   logic [5:0]  req_bits_wanted = 6'd0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [31:0] rsp_bits_out;
   logic        rsp_bits_valid;
   logic        rsp_short_of_bits;
   logic        rsp_byte_accepted;
   logic [1:0]  rsp_status;
   logic [6:0]  rsp_bits_held;
   logic [15:0] rsp_stuffers_seen;

   int   fail_count;
   int   outstanding;
   int   burst_left = 0;
   logic hold_wanted = 1'b0;
   int   hold_left = 0;
   int   stall_style = 0;
   int   style_left = 0;

   always #4 clock = ~clock;

   jpeg_bit_reader_unstuff_top u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_mode          (req_mode),
      .req_byte_in       (req_byte_in),
      .req_bits_wanted   (req_bits_wanted),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_bits_out      (rsp_bits_out),
      .rsp_bits_valid    (rsp_bits_valid),
      .rsp_short_of_bits (rsp_short_of_bits),
      .rsp_byte_accepted (rsp_byte_accepted),
      .rsp_status        (rsp_status),
      .rsp_bits_held     (rsp_bits_held),
      .rsp_stuffers_seen (rsp_stuffers_seen)
   );

   jbru_reader_checker u_checker (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_mode          (req_mode),
      .req_byte_in       (req_byte_in),
      .req_bits_wanted   (req_bits_wanted),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_bits_out      (rsp_bits_out),
      .rsp_bits_valid    (rsp_bits_valid),
      .rsp_short_of_bits (rsp_short_of_bits),
      .rsp_byte_accepted (rsp_byte_accepted),
      .rsp_status        (rsp_status),
      .rsp_bits_held     (rsp_bits_held),
      .rsp_stuffers_seen (rsp_stuffers_seen),
      .fail_count        (fail_count),
      .outstanding       (outstanding)
   );

   // Receiver back-pressure: random styles, plus one long hold when asked.
   always @(negedge clock) begin
      if (hold_wanted) begin
         hold_wanted = 1'b0;
         hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         if (style_left == 0) begin
            stall_style = $urandom_range(0, 3);
            style_left = $urandom_range(16, 200);
         end
         style_left--;
         case (stall_style)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= ($urandom_range(0, 3) == 0);
            2: rsp_stall <= ($urandom_range(0, 3) != 0);
            default: rsp_stall <= style_left[1];
         endcase
      end
   end

   // Called at a falling edge; returns at the falling edge after acceptance.
   task automatic offer(input logic [1:0] mode, input logic [7:0] octet,
                        input logic [5:0] wanted);
      if (burst_left == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(negedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 200)
                                                  : $urandom_range(1, 16);
      end
      req_valid <= 1'b1;
      req_mode <= mode;
      req_byte_in <= octet;
      req_bits_wanted <= wanted;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      burst_left--;
      @(negedge clock);
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      wait (outstanding == 0);
   endtask

   initial begin
      int         k;
      int         pick;
      int         push_share;
      logic [7:0] octet;
      logic [7:0] follower;
      logic [5:0] wanted;
      logic       marker_open;

      marker_open = 1'b0;
      push_share = 55;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      offer(MODE_READ, 8'h00, 6'd0);
      offer(MODE_READ, 8'h00, 6'd1);
      offer(MODE_PUSH, 8'h00, 6'd0);
      offer(MODE_PUSH, MarkerByte, 6'd0);
      offer(MODE_READ, 8'h00, 6'd8);
      offer(MODE_PUSH, StuffByte, 6'd0);
      offer(MODE_READ, 8'h00, 6'd63);
      offer(MODE_READ, 8'h00, 6'd8);
      for (k = 0; k < 8; k++) offer(MODE_PUSH, 8'($urandom_range(0, 254)), 6'd0);
      // The store is full now: a plain byte and a marker are both refused.
      offer(MODE_PUSH, 8'h7E, 6'd0);
      offer(MODE_PUSH, MarkerByte, 6'd0);
      offer(MODE_READ, 8'h00, 6'd32);
      offer(MODE_READ, 8'h00, 6'd40);
      offer(MODE_PUSH, StuffByte, 6'd0);
      offer(ModeUnused, 8'hFF, 6'd63);
      // A clear between a marker and its stuffing byte keeps the marker pending.
      offer(MODE_PUSH, MarkerByte, 6'd0);
      offer(MODE_CLEAR, 8'h00, 6'd0);
      offer(MODE_PUSH, StuffByte, 6'd0);
      offer(MODE_READ, 8'h00, 6'd8);

      for (k = 0; k < 1800; k++) begin
         if (k % 150 == 0) push_share = $urandom_range(35, 75);
         if (k == 600) hold_wanted = 1'b1;
         if (k == 1200) begin
            settle();
            @(negedge clock);
         end
         pick = $urandom_range(0, 99);
         if (pick < push_share) begin
            // Every marker is followed by a stuffing byte, so no error is raised here.
            if (marker_open) begin
               octet = StuffByte;
            end else if ($urandom_range(0, 7) == 0) begin
               octet = MarkerByte;
            end else begin
               octet = 8'($urandom_range(0, 255));
            end
            marker_open = (octet == MarkerByte);
            offer(MODE_PUSH, octet, 6'($urandom_range(0, 63)));
         end else if (pick < 95) begin
            if ($urandom_range(0, 9) == 0) begin
               wanted = 6'($urandom_range(33, 63));
            end else if ($urandom_range(0, 1) == 0) begin
               wanted = 6'($urandom_range(0, 8));
            end else begin
               wanted = 6'($urandom_range(0, 32));
            end
            offer(MODE_READ, 8'($urandom_range(0, 255)), wanted);
         end else if (pick < 98) begin
            offer(MODE_CLEAR, 8'($urandom_range(0, 255)), 6'($urandom_range(0, 63)));
         end else begin
            offer(ModeUnused, 8'($urandom_range(0, 255)), 6'($urandom_range(0, 63)));
         end
      end

      // Errors are sticky, so only one kind can be raised per run.
      offer(MODE_CLEAR, 8'h00, 6'd0);
      if (marker_open) offer(MODE_PUSH, StuffByte, 6'd0);
      repeat (4) offer(MODE_PUSH, 8'($urandom_range(0, 254)), 6'd0);
      offer(MODE_PUSH, MarkerByte, 6'd0);
      case ($urandom_range(0, 2))
         0: follower = MarkerByte;
         1: follower = {RestartHigh, 3'b000} + 8'($urandom_range(0, 7));
         default: begin
            do follower = 8'($urandom_range(1, 254));
            while (follower[7:3] == RestartHigh);
         end
      endcase
      offer(MODE_PUSH, follower, 6'd0);
      repeat (3) offer(MODE_PUSH, 8'($urandom_range(0, 255)), 6'd0);
      repeat (6) offer(MODE_READ, 8'h00, 6'd8);

      settle();
      repeat (8) @(posedge clock);
      if (fail_count == 0) begin
         $display("jpeg_bit_reader_unstuff_top regression: pass");
      end else begin
         $display("jpeg_bit_reader_unstuff_top regression: fail");
      end
      $finish;
   end

   initial begin
      #3_200_000;
      $display("jpeg_bit_reader_unstuff_top regression: fail");
      $finish;
   end

endmodule

FILE: filelist.f
rtl/jbru_pkg.sv
rtl/jbru_core.sv
rtl/jpeg_bit_reader_unstuff_top.sv
rtl/jbru_checker.sv
tb/sv/jbru_reader_checker.sv
tb/sv/tb_jpeg_bit_reader_unstuff_top.sv
